// ===== rtl/core/sexpr_token_lexer_unit_assert.svh =====
`ifndef SEXPR_TOKEN_LEXER_UNIT_ASSERT_SVH
`define SEXPR_TOKEN_LEXER_UNIT_ASSERT_SVH

// same-cycle check, clocked on i_clk, off during reset
`define STL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check in the cycle after the trigger
`define STL_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/stl_pkg.sv =====
package stl_pkg;

    localparam logic [3:0] CLS_EMPTY   = 4'd0;
    localparam logic [3:0] CLS_TRUE    = 4'd1;
    localparam logic [3:0] CLS_FALSE   = 4'd2;
    localparam logic [3:0] CLS_NUMBER  = 4'd3;
    localparam logic [3:0] CLS_STRING  = 4'd4;
    localparam logic [3:0] CLS_VECOPEN = 4'd5;
    localparam logic [3:0] CLS_OPEN    = 4'd6;
    localparam logic [3:0] CLS_CLOSE   = 4'd7;
    localparam logic [3:0] CLS_QUOTE   = 4'd8;
    localparam logic [3:0] CLS_BACKQ   = 4'd9;
    localparam logic [3:0] CLS_SPLICE  = 4'd10;
    localparam logic [3:0] CLS_UNQUOTE = 4'd11;
    localparam logic [3:0] CLS_DOT     = 4'd12;
    localparam logic [3:0] CLS_IDENT   = 4'd13;
    localparam logic [3:0] CLS_EOF     = 4'd14;
    localparam logic [3:0] CLS_ERROR   = 4'd15;

    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_COMMENT = 4'd1;
    localparam logic [3:0] MODE_QUOTE1  = 4'd2;
    localparam logic [3:0] MODE_QUOTE2  = 4'd3;
    localparam logic [3:0] MODE_HASH    = 4'd4;
    localparam logic [3:0] MODE_NUMBER  = 4'd5;
    localparam logic [3:0] MODE_STRING  = 4'd6;
    localparam logic [3:0] MODE_STRESC  = 4'd7;
    localparam logic [3:0] MODE_COMMA   = 4'd8;
    localparam logic [3:0] MODE_DOT     = 4'd9;
    localparam logic [3:0] MODE_IDENT   = 4'd10;
    localparam logic [3:0] MODE_ERROR   = 4'd11;

    localparam logic [2:0] TOK_MAX = 3'd4;

    typedef struct packed {
        logic [3:0]  token_class;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic [2:0]       cnt;
        t_token [3:0]     tok;
    } t_tok_list;

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic f_is_ident_first(input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (b) inside
            [8'h61:8'h7A], [8'h41:8'h5A],
            8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A, 8'h3C, 8'h3D,
            8'h3E, 8'h3F, 8'h7E, 8'h5F, 8'h5E, 8'h2B, 8'h2D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic f_is_ident_rest(input logic [7:0] b);
        return f_is_alpha(b) || f_is_digit(b) || b == 8'h2D || b == 8'h2B
            || b == 8'h2E || b == 8'h5F;
    endfunction

    function automatic logic [15:0] f_inc16(input logic [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    // append a token while room remains
    function automatic t_tok_list f_add(input t_tok_list l, input logic [3:0] cls,
                                        input logic [15:0] start, input logic [15:0] len);
        t_tok_list r;
        r = l;
        if (l.cnt < TOK_MAX) begin
            r.tok[l.cnt[1:0]].token_class  = cls;
            r.tok[l.cnt[1:0]].start_offset = start;
            r.tok[l.cnt[1:0]].token_length = len;
            r.tok[l.cnt[1:0]].last_of_run  = 1'b0;
            r.cnt = l.cnt + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/stl_stream_if.sv =====
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source(output valid, data_byte, final_byte, input ready);
    modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface stl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_class;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source(output valid, token_class, start_offset, token_length, last_of_run,
                   input ready);
    modport sink(input valid, token_class, start_offset, token_length, last_of_run,
                 output ready);
endinterface

// ===== rtl/core/stl_core.sv =====
module stl_core
    import stl_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_tok_list  o_list
);

    localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

    logic [3:0]           r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic [15:0]          r_cnt, n_cnt;
    logic [POS_WIDTH-1:0] r_pos, n_pos;

    function automatic logic [15:0] f_sat16(input logic [POS_WIDTH-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return (w > EXT_W'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [POS_WIDTH-1:0] f_pinc(input logic [POS_WIDTH-1:0] v);
        return (&v) ? v : v + POS_WIDTH'(1);
    endfunction

    always_comb begin
        t_tok_list            l;
        logic                 fresh;
        logic [15:0]          len1;
        logic [POS_WIDTH-1:0] pos_inc;
        logic [7:0]           b;

        b       = i_data_byte;
        l       = '0;
        fresh   = 1'b0;
        len1    = f_inc16(r_cnt);
        pos_inc = f_pinc(r_pos);
        n_mode  = r_mode;
        n_start = r_start;
        n_cnt   = r_cnt;

        case (r_mode)
            MODE_COMMENT: begin
                if (b == 8'h0A) fresh = 1'b1;
            end
            MODE_QUOTE1: begin
                if (b == 8'h28) begin
                    n_mode = MODE_QUOTE2;
                    n_cnt  = len1;
                end else begin
                    l     = f_add(l, CLS_QUOTE, f_sat16(r_start), 16'd1);
                    fresh = 1'b1;
                end
            end
            MODE_QUOTE2: begin
                if (b == 8'h29) begin
                    l      = f_add(l, CLS_EMPTY, f_sat16(r_start), 16'd3);
                    n_mode = MODE_IDLE;
                end else begin
                    l     = f_add(l, CLS_QUOTE, f_sat16(r_start), 16'd1);
                    l     = f_add(l, CLS_OPEN, f_sat16(f_pinc(r_start)), 16'd1);
                    fresh = 1'b1;
                end
            end
            MODE_HASH: begin
                n_cnt = len1;
                if (b == 8'h74) begin
                    l      = f_add(l, CLS_TRUE, f_sat16(r_start), 16'd2);
                    n_mode = MODE_IDLE;
                end else if (b == 8'h66) begin
                    l      = f_add(l, CLS_FALSE, f_sat16(r_start), 16'd2);
                    n_mode = MODE_IDLE;
                end else if (b == 8'h28) begin
                    l      = f_add(l, CLS_VECOPEN, f_sat16(r_start), 16'd2);
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_ERROR;
                end
            end
            MODE_NUMBER: begin
                if (f_is_digit(b)) begin
                    n_cnt = len1;
                end else begin
                    l     = f_add(l, CLS_NUMBER, f_sat16(r_start), r_cnt);
                    fresh = 1'b1;
                end
            end
            MODE_STRING: begin
                n_cnt = len1;
                if (b == 8'h22) begin
                    l      = f_add(l, CLS_STRING, f_sat16(r_start), len1);
                    n_mode = MODE_IDLE;
                end else if (b == 8'h5C) begin
                    n_mode = MODE_STRESC;
                end
            end
            MODE_STRESC: begin
                n_cnt  = len1;
                n_mode = (b == 8'h22 || b == 8'h5C) ? MODE_STRING : MODE_ERROR;
            end
            MODE_COMMA: begin
                if (b == 8'h40) begin
                    l      = f_add(l, CLS_SPLICE, f_sat16(r_start), 16'd2);
                    n_mode = MODE_IDLE;
                end else begin
                    l     = f_add(l, CLS_UNQUOTE, f_sat16(r_start), 16'd1);
                    fresh = 1'b1;
                end
            end
            MODE_DOT: begin
                n_cnt = len1;
                if (b == 8'h20) begin
                    l      = f_add(l, CLS_DOT, f_sat16(r_start), 16'd2);
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_ERROR;
                end
            end
            MODE_IDENT: begin
                if (f_is_ident_rest(b)) begin
                    n_cnt = len1;
                end else begin
                    l     = f_add(l, CLS_IDENT, f_sat16(r_start), r_cnt);
                    fresh = 1'b1;
                end
            end
            MODE_ERROR: begin
                n_cnt = len1;
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // new token starts with this byte
        if (fresh) begin
            n_start = r_pos;
            n_cnt   = 16'd1;
            n_mode  = MODE_IDLE;
            if (f_is_space(b)) begin
                n_mode = MODE_IDLE;
            end else if (b == 8'h3B) begin
                n_mode = MODE_COMMENT;
            end else if (b == 8'h27) begin
                n_mode = MODE_QUOTE1;
            end else if (b == 8'h23) begin
                n_mode = MODE_HASH;
            end else if (f_is_digit(b)) begin
                n_mode = MODE_NUMBER;
            end else if (b == 8'h22) begin
                n_mode = MODE_STRING;
            end else if (b == 8'h28) begin
                l = f_add(l, CLS_OPEN, f_sat16(r_pos), 16'd1);
            end else if (b == 8'h29) begin
                l = f_add(l, CLS_CLOSE, f_sat16(r_pos), 16'd1);
            end else if (b == 8'h60) begin
                l = f_add(l, CLS_BACKQ, f_sat16(r_pos), 16'd1);
            end else if (b == 8'h2C) begin
                n_mode = MODE_COMMA;
            end else if (b == 8'h2E) begin
                n_mode = MODE_DOT;
            end else if (f_is_ident_first(b)) begin
                n_mode = MODE_IDENT;
            end else begin
                n_mode = MODE_ERROR;
            end
        end

        n_pos = pos_inc;

        // end of text: flush pending token, add eof, restart
        if (i_final_byte) begin
            case (n_mode)
                MODE_QUOTE1: l = f_add(l, CLS_QUOTE, f_sat16(n_start), 16'd1);
                MODE_QUOTE2: begin
                    l = f_add(l, CLS_QUOTE, f_sat16(n_start), 16'd1);
                    l = f_add(l, CLS_OPEN, f_sat16(f_pinc(n_start)), 16'd1);
                end
                MODE_NUMBER: l = f_add(l, CLS_NUMBER, f_sat16(n_start), n_cnt);
                MODE_COMMA:  l = f_add(l, CLS_UNQUOTE, f_sat16(n_start), 16'd1);
                MODE_IDENT:  l = f_add(l, CLS_IDENT, f_sat16(n_start), n_cnt);
                MODE_HASH, MODE_STRING, MODE_STRESC, MODE_DOT, MODE_ERROR:
                    l = f_add(l, CLS_ERROR, f_sat16(n_start), n_cnt);
                default: ;
            endcase
            l       = f_add(l, CLS_EOF, f_sat16(pos_inc), 16'd0);
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_cnt   = '0;
            n_pos   = '0;
        end

        if (l.cnt != 3'd0) begin
            l.tok[l.cnt[1:0] - 2'd1].last_of_run = 1'b1;
        end
        o_list = l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

endmodule

// ===== rtl/core/stl_token_queue.sv =====
`include "sexpr_token_lexer_unit_assert.svh"

module stl_token_queue
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_tok_list  i_list,
    output logic       o_free,
    stl_out_if.source  o_out
);

    logic [2:0]   r_cnt;
    t_token [3:0] r_tok;
    logic         w_pop;

    assign o_out.valid        = (r_cnt != 3'd0);
    assign o_out.token_class  = r_tok[0].token_class;
    assign o_out.start_offset = r_tok[0].start_offset;
    assign o_out.token_length = r_tok[0].token_length;
    assign o_out.last_of_run  = r_tok[0].last_of_run;

    assign w_pop  = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_list.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_list.tok;
        end else if (w_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_tok[i] <= r_tok[i + 1];
            end
        end
    end

    `STL_ASSERT(a_cnt_bound, r_cnt <= TOK_MAX, "token queue count above capacity")
    `STL_ASSERT(a_load_free, !i_load || o_free, "token queue loaded while busy")
    `STL_ASSERT(a_last_tail, r_cnt != 3'd1 || r_tok[0].last_of_run, "final token lacks last flag")
    `STL_ASSERT_NEXT(a_load_cnt, i_load, r_cnt == $past(i_list.cnt), "token count not loaded")

endmodule

// ===== rtl/core/sexpr_token_lexer_unit.sv =====
// Streaming S-expression lexer: one source byte per transaction on i_in, one token per
// transaction on o_out (class, start offset, length, last flag on the final token of a
// byte). A byte is registered, lexed in a single pass and its tokens (at most four) are
// loaded into a four-entry result queue that drains one token per cycle while o_out is
// ready. Bytes that cause no token sustain one byte per cycle, as do bytes that cause one
// token while o_out is ready; after a byte that causes several tokens the next byte
// that causes tokens is held while the queue drains. The final_byte flag adds the
// end-of-file token and restarts offsets at zero for the next text.
module sexpr_token_lexer_unit
    import stl_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stl_in_if.sink    i_in,
    stl_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    t_tok_list  w_list;
    logic       w_free;
    logic       w_fire;
    logic       w_load;
    logic       w_accept;

    assign w_fire   = r_in_valid && (w_list.cnt == 3'd0 || w_free);
    assign w_load   = w_fire && (w_list.cnt != 3'd0);
    assign i_in.ready = !r_in_valid || w_fire;
    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in.data_byte;
            r_fin  <= i_in.final_byte;
        end
    end

    stl_core #(
        .POS_WIDTH(POS_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_data_byte  (r_byte),
        .i_final_byte (r_fin),
        .o_list       (w_list)
    );

    stl_token_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_list  (w_list),
        .o_free  (w_free),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/tb_sexpr_token_lexer_unit.sv =====
`timescale 1ns / 1ps

module tb_sexpr_token_lexer_unit;
    import stl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 350;
    localparam int SETTLE_CYCLES  = 20;

    logic clk;
    logic rst_n;

    stl_in_if  in_ch();
    stl_out_if out_ch();

    sexpr_token_lexer_unit dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // lexer state as predicted
    logic [3:0]  lx_mode  = MODE_IDLE;
    logic [15:0] lx_start = '0;
    logic [15:0] lx_len   = '0;
    logic [15:0] lx_pos   = '0;

    t_token      step_tokens[$];
    t_token      expected_tokens[$];
    logic [7:0]  text_buf[$];

    int          err_count      = 0;
    int          tokens_checked = 0;
    int          bytes_lexed    = 0;
    int          texts_lexed    = 0;
    logic [15:0] class_seen     = '0;
    bit          no_stall       = 1'b0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // lexer predictor

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C
            || b == 8'h0D;
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit opens_ident(input logic [7:0] b);
        string marks;
        marks = "!$%&*/:<=>?~_^+-";
        if (is_letter(b))
            return 1'b1;
        foreach (marks[i])
            if (marks[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit extends_ident(input logic [7:0] b);
        return is_letter(b) || is_num(b) || b == "-" || b == "+" || b == "." || b == "_";
    endfunction

    task automatic push_token(input logic [3:0] cls, input logic [15:0] st,
                              input logic [15:0] ln);
        t_token t;
        if (step_tokens.size() < 4) begin
            t.token_class  = cls;
            t.start_offset = st;
            t.token_length = ln;
            t.last_of_run  = 1'b0;
            step_tokens.push_back(t);
        end
    endtask

    task automatic begin_token(input logic [7:0] b, input logic [15:0] p);
        lx_start = p;
        lx_len   = 16'd1;
        lx_mode  = MODE_IDLE;
        if (is_blank(b))
            lx_mode = MODE_IDLE;
        else if (b == ";")
            lx_mode = MODE_COMMENT;
        else if (b == "'")
            lx_mode = MODE_QUOTE1;
        else if (b == "#")
            lx_mode = MODE_HASH;
        else if (is_num(b))
            lx_mode = MODE_NUMBER;
        else if (b == "\"")
            lx_mode = MODE_STRING;
        else if (b == "(")
            push_token(CLS_OPEN, p, 16'd1);
        else if (b == ")")
            push_token(CLS_CLOSE, p, 16'd1);
        else if (b == 8'h60)
            push_token(CLS_BACKQ, p, 16'd1);
        else if (b == ",")
            lx_mode = MODE_COMMA;
        else if (b == ".")
            lx_mode = MODE_DOT;
        else if (opens_ident(b))
            lx_mode = MODE_IDENT;
        else
            lx_mode = MODE_ERROR;
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic fin);
        logic [15:0] p;
        logic [15:0] len1;
        t_token      t;
        step_tokens.delete();
        p    = lx_pos;
        len1 = sat_up(lx_len);
        case (lx_mode)
            MODE_COMMENT: begin
                if (b == 8'h0A)
                    begin_token(b, p);
            end
            MODE_QUOTE1: begin
                if (b == "(") begin
                    lx_mode = MODE_QUOTE2;
                    lx_len  = len1;
                end else begin
                    push_token(CLS_QUOTE, lx_start, 16'd1);
                    begin_token(b, p);
                end
            end
            MODE_QUOTE2: begin
                if (b == ")") begin
                    push_token(CLS_EMPTY, lx_start, 16'd3);
                    lx_mode = MODE_IDLE;
                end else begin
                    push_token(CLS_QUOTE, lx_start, 16'd1);
                    push_token(CLS_OPEN, sat_up(lx_start), 16'd1);
                    begin_token(b, p);
                end
            end
            MODE_HASH: begin
                lx_len = len1;
                if (b == "t") begin
                    push_token(CLS_TRUE, lx_start, 16'd2);
                    lx_mode = MODE_IDLE;
                end else if (b == "f") begin
                    push_token(CLS_FALSE, lx_start, 16'd2);
                    lx_mode = MODE_IDLE;
                end else if (b == "(") begin
                    push_token(CLS_VECOPEN, lx_start, 16'd2);
                    lx_mode = MODE_IDLE;
                end else begin
                    lx_mode = MODE_ERROR;
                end
            end
            MODE_NUMBER: begin
                if (is_num(b)) begin
                    lx_len = len1;
                end else begin
                    push_token(CLS_NUMBER, lx_start, lx_len);
                    begin_token(b, p);
                end
            end
            MODE_STRING: begin
                lx_len = len1;
                if (b == "\"") begin
                    push_token(CLS_STRING, lx_start, len1);
                    lx_mode = MODE_IDLE;
                end else if (b == "\\") begin
                    lx_mode = MODE_STRESC;
                end
            end
            MODE_STRESC: begin
                lx_len  = len1;
                lx_mode = (b == "\"" || b == "\\") ? MODE_STRING : MODE_ERROR;
            end
            MODE_COMMA: begin
                if (b == "@") begin
                    push_token(CLS_SPLICE, lx_start, 16'd2);
                    lx_mode = MODE_IDLE;
                end else begin
                    push_token(CLS_UNQUOTE, lx_start, 16'd1);
                    begin_token(b, p);
                end
            end
            MODE_DOT: begin
                lx_len = len1;
                if (b == " ") begin
                    push_token(CLS_DOT, lx_start, 16'd2);
                    lx_mode = MODE_IDLE;
                end else begin
                    lx_mode = MODE_ERROR;
                end
            end
            MODE_IDENT: begin
                if (extends_ident(b)) begin
                    lx_len = len1;
                end else begin
                    push_token(CLS_IDENT, lx_start, lx_len);
                    begin_token(b, p);
                end
            end
            MODE_ERROR: lx_len = len1;
            default:    begin_token(b, p);
        endcase

        lx_pos = sat_up(lx_pos);

        if (fin) begin
            case (lx_mode)
                MODE_QUOTE1: push_token(CLS_QUOTE, lx_start, 16'd1);
                MODE_QUOTE2: begin
                    push_token(CLS_QUOTE, lx_start, 16'd1);
                    push_token(CLS_OPEN, sat_up(lx_start), 16'd1);
                end
                MODE_NUMBER: push_token(CLS_NUMBER, lx_start, lx_len);
                MODE_COMMA:  push_token(CLS_UNQUOTE, lx_start, 16'd1);
                MODE_IDENT:  push_token(CLS_IDENT, lx_start, lx_len);
                MODE_HASH, MODE_STRING, MODE_STRESC, MODE_DOT, MODE_ERROR:
                    push_token(CLS_ERROR, lx_start, lx_len);
                default: ;
            endcase
            push_token(CLS_EOF, lx_pos, 16'd0);
            lx_mode  = MODE_IDLE;
            lx_start = '0;
            lx_len   = '0;
            lx_pos   = '0;
        end

        foreach (step_tokens[i]) begin
            t = step_tokens[i];
            if (i == step_tokens.size() - 1)
                t.last_of_run = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    // result checking

    task automatic check_token(input t_token got);
        t_token want;
        bit     bad;
        tokens_checked++;
        class_seen[got.token_class] = 1'b1;
        if (expected_tokens.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("[%0t] unexpected token: class %0d start %0d len %0d last %0b",
                         $realtime, got.token_class, got.start_offset, got.token_length,
                         got.last_of_run);
            return;
        end
        want = expected_tokens.pop_front();
        bad  = (got.token_class !== want.token_class)
            || (got.start_offset !== want.start_offset)
            || (got.token_length !== want.token_length)
            || (got.last_of_run !== want.last_of_run);
        if (bad) begin
            err_count++;
            if (err_count <= 10) begin
                $display("[%0t] token mismatch: expected class %0d start %0d len %0d last %0b",
                         $realtime, want.token_class, want.start_offset,
                         want.token_length, want.last_of_run);
                $display("    got class %0d start %0d len %0d last %0b",
                         got.token_class, got.start_offset, got.token_length,
                         got.last_of_run);
            end
        end
    endtask

    always @(posedge clk) begin
        t_token got;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.token_class  = out_ch.token_class;
                got.start_offset = out_ch.start_offset;
                got.token_length = out_ch.token_length;
                got.last_of_run  = out_ch.last_of_run;
                check_token(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                lex_byte(in_ch.data_byte, in_ch.final_byte);
                bytes_lexed++;
                if (in_ch.final_byte)
                    texts_lexed++;
            end
        end
    end

    // sink backpressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= no_stall ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL sexpr_token_lexer_unit");
        $finish;
    end

    // stimulus helpers, all entered at a falling edge

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!no_stall && $urandom_range(99) < 15) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit fin);
        foreach (s[i])
            send_byte(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic send_buffer();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_str(input string s);
        foreach (s[i])
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? 8'h61 : 8'h41;
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic add_fragment();
        int         kind;
        logic [7:0] c;
        if ($urandom_range(99) < 8) begin
            text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        kind = $urandom_range(15);
        case (kind)
            0:  add_str("'()");
            1:  add_str("#t");
            2:  add_str("#f");
            3:  repeat ($urandom_range(4, 1)) text_buf.push_back(8'h30 + 8'($urandom_range(9)));
            4: begin
                text_buf.push_back("\"");
                repeat ($urandom_range(5)) begin
                    case ($urandom_range(9))
                        0: add_str("\\\"");
                        1: add_str("\\\\");
                        default: begin
                            c = 8'($urandom_range(255));
                            if (c == "\"" || c == "\\")
                                c = "x";
                            text_buf.push_back(c);
                        end
                    endcase
                end
                if ($urandom_range(19) == 0)
                    add_str("\\n");
                text_buf.push_back("\"");
            end
            5:  add_str("#(");
            6:  add_str("(");
            7:  add_str(")");
            8:  add_str("'");
            9:  text_buf.push_back(8'h60);
            10: add_str(",@");
            11: add_str(",");
            12: add_str(". ");
            13: begin
                c = $urandom_range(2) ? rand_letter() : pick_from("!$%&*/:<=>?~_^+-");
                text_buf.push_back(c);
                repeat ($urandom_range(5)) begin
                    c = $urandom_range(2) ? rand_letter() : pick_from("0123456789-+._");
                    text_buf.push_back(c);
                end
            end
            14: begin
                text_buf.push_back(";");
                repeat ($urandom_range(6)) begin
                    c = 8'($urandom_range(255));
                    text_buf.push_back(c == 8'h0A ? 8'h00 : c);
                end
                text_buf.push_back(8'h0A);
            end
            default: begin
                add_str("'(");
                text_buf.push_back(rand_letter());
            end
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: text_buf.push_back(" ");
            4:          text_buf.push_back(pick_from("\t\n\v\f\r"));
            5:          text_buf.push_back(pick_from("()"));
            default:    ;
        endcase
    endtask

    // tests

    task automatic test_token_classes();
        send_text("'() #t #f 90 \"a\\\"\\\\\" #( ( ) ' ", 0);
        send_byte(8'h60, 0);
        send_text(" ,@ , . xQ-1+.b_Z !$%&*/:<=>?~_^+-", 1);
    endtask

    task automatic test_special_cases();
        send_text("12ab'(x", 1);
        send_text("\"a\\n\" z", 1);
        send_text("#q1", 1);
        send_text(".x y", 1);
        send_text("; c", 0);
        send_byte(8'h00, 0);
        send_text("\n5\"", 0);
        send_byte(8'h00, 0);
        send_text("\" ", 0);
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
    endtask

    task automatic test_cut_off_at_end();
        string cases[12];
        cases = '{"'", "'(", "12", ",", "ab", "#", ".", "\"ab", "\"a\\", "; x", "  ", ")"};
        foreach (cases[i])
            send_text(cases[i], 1);
    endtask

    task automatic test_drain_pause();
        send_text("(a b", 0);
        wait_drained();
        send_text(" c)", 1);
    endtask

    task automatic test_random_texts();
        int sent;
        int n;
        sent = 0;
        n    = 0;
        while (sent < RANDOM_BYTES) begin
            no_stall = (sent >= 200 && sent < 320);
            text_buf.delete();
            repeat ($urandom_range(8, 1))
                add_fragment();
            send_buffer();
            sent += text_buf.size();
            n++;
            if (n % 25 == 0)
                wait_drained();
        end
        no_stall = 1'b0;
    endtask

    task automatic test_long_token();
        no_stall = 1'b1;
        send_byte("a", 0);
        repeat (60)
            send_byte("b", 0);
        send_text(" 7(", 0);
        send_byte(8'h80, 0);
        send_text("zz", 1);
        no_stall = 1'b0;
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        rst_n            = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_token_classes();
        test_special_cases();
        test_cut_off_at_end();
        test_drain_pause();
        test_random_texts();
        test_long_token();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d texts, %0d tokens checked, %0d errors",
                 bytes_lexed, texts_lexed, tokens_checked, err_count);
        $display("token classes seen (bit per class): %b", class_seen);
        if (err_count == 0 && expected_tokens.size() == 0)
            $display("PASS sexpr_token_lexer_unit");
        else
            $display("FAIL sexpr_token_lexer_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_stream_if.sv
rtl/core/stl_core.sv
rtl/core/stl_token_queue.sv
rtl/core/sexpr_token_lexer_unit.sv
tb/sv/tb_sexpr_token_lexer_unit.sv
